>>> rtl/core/tmwf_pkg.sv
package tmwf_pkg;

  localparam int unsigned WINDOW      = 8;
  localparam int unsigned SAMPLE_BITS = 16;

  localparam int unsigned IDX_W  = $clog2(WINDOW);
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W  = SAMPLE_BITS + IDX_W;
  localparam int unsigned STEP_W = $clog2(SAMPLE_BITS);

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned FILTERED_W = 16;
  localparam int unsigned USED_W     = 4;

  localparam int unsigned MIN_TRIM_COUNT = 4;

  typedef struct packed {
    logic start;
    logic scan;
    logic prep;
    logic div;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic use_div;
    logic div_last;
  } dp_sts_t;

endpackage

>>> rtl/core/tmwf_datapath.sv
module tmwf_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tmwf_pkg::dp_cmd_t                 cmd_i,
  output tmwf_pkg::dp_sts_t                 sts_o,
  input  logic [tmwf_pkg::SAMPLE_W-1:0]     sample_i,
  output logic [tmwf_pkg::FILTERED_W-1:0]   filtered_o,
  output logic [tmwf_pkg::USED_W-1:0]       used_count_o
);
  import tmwf_pkg::*;

  logic [SAMPLE_BITS-1:0] win_q [WINDOW];

  logic [IDX_W-1:0]       pos_q, pos_d;
  logic                   full_q, full_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [SAMPLE_BITS-1:0] min_q, min_d;
  logic [SAMPLE_BITS-1:0] max_q, max_d;
  logic [CNT_W-1:0]       rem_q, rem_d;
  logic [SAMPLE_BITS-1:0] quo_q, quo_d;
  logic [STEP_W-1:0]      step_q, step_d;
  logic [SAMPLE_BITS-1:0] out_q;
  logic [USED_W-1:0]      used_q;

  logic [SAMPLE_BITS-1:0] entry;
  logic [SUM_W-1:0]       trimmed;
  logic [CNT_W-1:0]       divisor;
  logic [CNT_W:0]         trial;
  logic                   div_ge;

  assign entry   = win_q[idx_q];
  assign trimmed = sum_q - SUM_W'(min_q) - SUM_W'(max_q);
  assign divisor = count_q - CNT_W'(2);
  assign trial   = {rem_q, quo_q[SAMPLE_BITS-1]};
  assign div_ge  = trial >= {1'b0, divisor};

  assign sts_o.scan_last = CNT_W'(idx_q) == (count_q - CNT_W'(1));
  assign sts_o.use_div   = count_q >= CNT_W'(MIN_TRIM_COUNT);
  assign sts_o.div_last  = step_q == '0;

  // window entries carry no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      win_q[pos_q] <= SAMPLE_BITS'(sample_i);
    end
  end

  always_comb begin
    pos_d  = pos_q;
    full_d = full_q;
    if (cmd_i.start) begin
      if (pos_q == IDX_W'(WINDOW - 1)) begin
        pos_d  = '0;
        full_d = 1'b1;
      end else begin
        pos_d = pos_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      full_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      full_q <= full_d;
    end
  end

  always_comb begin
    count_d = count_q;
    idx_d   = idx_q;
    sum_d   = sum_q;
    min_d   = min_q;
    max_d   = max_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    step_d  = step_q;
    if (cmd_i.start) begin
      count_d = full_q ? CNT_W'(WINDOW) : CNT_W'(pos_q) + CNT_W'(1);
      idx_d   = '0;
      sum_d   = '0;
      min_d   = '1;
      max_d   = '0;
    end
    if (cmd_i.scan) begin
      idx_d = idx_q + IDX_W'(1);
      sum_d = sum_q + SUM_W'(entry);
      if (entry < min_q) begin
        min_d = entry;
      end
      if (entry > max_q) begin
        max_d = entry;
      end
    end
    if (cmd_i.prep) begin
      step_d = STEP_W'(SAMPLE_BITS - 1);
      // three entries: sum minus min and max is the median
      priority if (sts_o.use_div) begin
        rem_d = CNT_W'(trimmed[SUM_W-1:SAMPLE_BITS]);
        quo_d = trimmed[SAMPLE_BITS-1:0];
      end else if (count_q == CNT_W'(1)) begin
        quo_d = sum_q[SAMPLE_BITS-1:0];
      end else if (count_q == CNT_W'(2)) begin
        quo_d = max_q;
      end else begin
        quo_d = trimmed[SAMPLE_BITS-1:0];
      end
    end
    if (cmd_i.div) begin
      step_d = step_q - STEP_W'(1);
      quo_d  = {quo_q[SAMPLE_BITS-2:0], div_ge};
      rem_d  = div_ge ? CNT_W'(trial - {1'b0, divisor}) : CNT_W'(trial);
    end
  end

  always_ff @(posedge clk_i) begin
    count_q <= count_d;
    idx_q   <= idx_d;
    sum_q   <= sum_d;
    min_q   <= min_d;
    max_q   <= max_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    step_q  <= step_d;
    if (cmd_i.load) begin
      out_q  <= quo_q;
      used_q <= USED_W'(count_q);
    end
  end

  assign filtered_o   = FILTERED_W'(out_q);
  assign used_count_o = used_q;

endmodule

>>> rtl/core/tmwf_ctrl.sv
module tmwf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tmwf_pkg::dp_cmd_t cmd_o,
  input  tmwf_pkg::dp_sts_t sts_i
);
  import tmwf_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_PREP = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_LOAD = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = sts_i.use_div ? ST_DIV : ST_LOAD;
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (out_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten while stalled");

  a_accept_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_SCAN))
    else $error("accepted transaction not scanned");

  a_short_skips_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PREP && !sts_i.use_div) |=> (state_q == ST_LOAD))
    else $error("short window entered divider");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> out_valid_q)
    else $error("loaded result not presented");

endmodule

>>> rtl/core/trimmed_mean_window_filter.sv
// Trimmed-mean filter over a ring of the last WINDOW (8) samples. Each input
// transaction writes one sample into the ring; before the ring has wrapped only
// the samples written so far count. With four or more entries the smallest and
// largest are dropped and the truncated mean of the rest is returned; with
// fewer, the median (the larger of two). used_count gives how many entries took
// part. One transaction is processed at a time: accept, a scan of count
// entries (one per cycle), a prep step, then, when four or more entries are
// used, the restoring divider with one quotient bit per cycle for SAMPLE_BITS
// (16) bits, and a load of the output register, which waits while an earlier
// result is still pending. The next sample is accepted while a finished result
// waits in the output register.
module trimmed_mean_window_filter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [tmwf_pkg::SAMPLE_W-1:0]     sample_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [tmwf_pkg::FILTERED_W-1:0]   filtered_o,
  output logic [tmwf_pkg::USED_W-1:0]       used_count_o
);
  import tmwf_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  tmwf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  tmwf_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .sample_i     (sample_i),
    .filtered_o   (filtered_o),
    .used_count_o (used_count_o)
  );

endmodule
